// ----- rtl/wpsd_pkg.sv -----
package wpsd_pkg;

  localparam int unsigned WINDOW      = 12;
  localparam int unsigned COORD_BITS  = 12;

  localparam int unsigned PTR_BITS    = $clog2(WINDOW);
  localparam int unsigned CNT_BITS    = $clog2(WINDOW + 2);
  localparam int unsigned SUM_BITS    = COORD_BITS + $clog2(WINDOW);
  localparam int unsigned SQ_BITS     = 2 * COORD_BITS + $clog2(WINDOW);
  localparam int unsigned PROD_BITS   = 2 * SUM_BITS;
  localparam int unsigned RING_BITS   = 2 * COORD_BITS;

  localparam int unsigned LIMIT_BITS   = 20;
  localparam int unsigned TIMEOUT_BITS = 16;
  localparam int unsigned N_SQ         = WINDOW * WINDOW;
  localparam int unsigned LIM_SC_BITS  = LIMIT_BITS + $clog2(N_SQ + 1);
  localparam int unsigned CMP_BITS     = (PROD_BITS > LIM_SC_BITS) ? PROD_BITS : LIM_SC_BITS;

  localparam int unsigned LIMIT_RESET   = 16;
  localparam int unsigned TIMEOUT_RESET = 30;

  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = LIMIT_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_VARIANCE_LIMIT = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_TIMEOUT   = CFG_IDX_BITS'(1);

  localparam logic [CNT_BITS-1:0] CNT_WINDOW = CNT_BITS'(WINDOW);
  localparam logic [CNT_BITS-1:0] CNT_FULL   = CNT_BITS'(WINDOW + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST   = PTR_BITS'(WINDOW - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_OX,
    S_MUL_OY,
    S_MUL_NX,
    S_MUL_NY,
    S_MUL_SX,
    S_MUL_SY,
    S_CMP_Y,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    MUL_OLD_X,
    MUL_OLD_Y,
    MUL_NEW_X,
    MUL_NEW_Y,
    MUL_SUM_X,
    MUL_SUM_Y
  } mul_sel_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     sub_x;
    logic     sub_y;
    logic     add_x;
    logic     add_y;
    logic     cmp_x;
    logic     cmp_y;
    logic     out_load;
    logic     ready;
  } ctrl_t;

endpackage

// ----- rtl/wpsd_if.sv -----
interface wpsd_in_if
  import wpsd_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  blob_present;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;

  modport source (output valid, blob_present, pos_x, pos_y, input ready);
  modport sink   (input valid, blob_present, pos_x, pos_y, output ready);
endinterface

interface wpsd_out_if;
  logic valid;
  logic ready;
  logic stable;
  logic window_cleared;

  modport source (output valid, stable, window_cleared, input ready);
  modport sink   (input valid, stable, window_cleared, output ready);
endinterface

interface wpsd_cfg_if
  import wpsd_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  reg_index;
  logic [CFG_DATA_BITS-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- rtl/windowed_position_stability_detector_core.sv -----
// A blob item steps through the six multiply states and S_CMP_Y to S_DONE; an idle item goes to S_DONE directly.
// A new item is taken only in S_IDLE, after the last one has left S_DONE; a single shared
// 16x16 multiplier is stepped through six products per blob item by the sequencer.
// A finished result waits in the output register while the next item is taken.
// Reset (async, active low) clears sums, counts, pointer and the output register and
// loads variance_limit = 16, idle_timeout = 30; position ring contents are not reset.
module windowed_position_stability_detector_core
  import wpsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  wpsd_in_if.sink     item_i,
  wpsd_out_if.source  result_o,
  wpsd_cfg_if.sink    cfg_i
);

  ctrl_t ctl;
  logic  accept;
  logic  out_free;

  logic [COORD_BITS-1:0]   x_q, y_q;
  logic                    full_q;
  logic [SUM_BITS-1:0]     sum_x_q, sum_y_q;
  logic [SQ_BITS-1:0]      sq_x_q, sq_y_q;
  logic [PTR_BITS-1:0]     ptr_q;
  logic [CNT_BITS-1:0]     cnt_q;
  logic [TIMEOUT_BITS-1:0] idle_q;
  logic [TIMEOUT_BITS-1:0] timeout_q;
  logic [LIM_SC_BITS-1:0]  lim_q;
  logic                    ok_x_q;
  logic                    res_stable_q, res_clr_q;
  logic                    out_valid_q, out_stable_q, out_clr_q;

  logic [RING_BITS-1:0]    ring_rd;
  logic [COORD_BITS-1:0]   old_x, old_y;
  logic [SUM_BITS-1:0]     mul_a;
  logic [PROD_BITS-1:0]    prod;
  logic [TIMEOUT_BITS:0]   idle_next;
  logic                    timed_out;
  logic [CMP_BITS-1:0]     spread_x, spread_y;
  logic                    ok_x, ok_y;

  assign accept   = item_i.valid && ctl.ready;
  assign out_free = !out_valid_q || result_o.ready;

  assign item_i.ready = ctl.ready;
  assign cfg_i.ready  = 1'b1;

  wpsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .blob_i     (item_i.blob_present),
    .out_free_i (out_free),
    .ctrl_o     (ctl)
  );

  wpsd_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (ctl.add_x),
    .waddr_i (ptr_q),
    .wdata_i ({x_q, y_q}),
    .re_i    (accept),
    .raddr_i (ptr_q),
    .rdata_o (ring_rd)
  );

  assign old_x = ring_rd[RING_BITS-1:COORD_BITS];
  assign old_y = ring_rd[COORD_BITS-1:0];

  always_comb begin
    case (ctl.mul_sel)
      MUL_OLD_X: mul_a = SUM_BITS'(old_x);
      MUL_OLD_Y: mul_a = SUM_BITS'(old_y);
      MUL_NEW_X: mul_a = SUM_BITS'(x_q);
      MUL_NEW_Y: mul_a = SUM_BITS'(y_q);
      MUL_SUM_X: mul_a = sum_x_q;
      MUL_SUM_Y: mul_a = sum_y_q;
      default:   mul_a = '0;
    endcase
  end

  wpsd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_a),
    .prod_o (prod)
  );

  // N*sumsq - sum^2 < limit*N^2
  assign spread_x = CMP_BITS'(sq_x_q) * CMP_BITS'(WINDOW) - CMP_BITS'(prod);
  assign spread_y = CMP_BITS'(sq_y_q) * CMP_BITS'(WINDOW) - CMP_BITS'(prod);
  assign ok_x     = spread_x < CMP_BITS'(lim_q);
  assign ok_y     = spread_y < CMP_BITS'(lim_q);

  assign idle_next = {1'b0, idle_q} + (TIMEOUT_BITS + 1)'(1);
  assign timed_out = idle_next > {1'b0, timeout_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q     <= LIM_SC_BITS'(LIMIT_RESET * N_SQ);
      timeout_q <= TIMEOUT_BITS'(TIMEOUT_RESET);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        REG_VARIANCE_LIMIT: begin
          lim_q <= LIM_SC_BITS'(cfg_i.wdata[LIMIT_BITS-1:0]) * LIM_SC_BITS'(N_SQ);
        end
        REG_IDLE_TIMEOUT: timeout_q <= cfg_i.wdata[TIMEOUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= item_i.pos_x;
      y_q <= item_i.pos_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q       <= 1'b0;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      sq_x_q       <= '0;
      sq_y_q       <= '0;
      ptr_q        <= '0;
      cnt_q        <= '0;
      idle_q       <= '0;
      ok_x_q       <= 1'b0;
      res_stable_q <= 1'b0;
      res_clr_q    <= 1'b0;
    end else begin
      if (accept) begin
        res_stable_q <= 1'b0;
        if (item_i.blob_present) begin
          idle_q    <= '0;
          full_q    <= cnt_q >= CNT_WINDOW;
          res_clr_q <= 1'b0;
        end else if (timed_out) begin
          idle_q    <= '0;
          sum_x_q   <= '0;
          sum_y_q   <= '0;
          sq_x_q    <= '0;
          sq_y_q    <= '0;
          ptr_q     <= '0;
          cnt_q     <= '0;
          res_clr_q <= 1'b1;
        end else begin
          idle_q    <= idle_next[TIMEOUT_BITS-1:0];
          res_clr_q <= 1'b0;
        end
      end
      if (ctl.sub_x && full_q) begin
        sum_x_q <= sum_x_q - SUM_BITS'(old_x);
        sq_x_q  <= sq_x_q - SQ_BITS'(prod);
      end
      if (ctl.sub_y && full_q) begin
        sum_y_q <= sum_y_q - SUM_BITS'(old_y);
        sq_y_q  <= sq_y_q - SQ_BITS'(prod);
      end
      if (ctl.add_x) begin
        sum_x_q <= sum_x_q + SUM_BITS'(x_q);
        sq_x_q  <= sq_x_q + SQ_BITS'(prod);
        ptr_q   <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_BITS'(1);
        if (cnt_q != CNT_FULL) begin
          cnt_q <= cnt_q + CNT_BITS'(1);
        end
      end
      if (ctl.add_y) begin
        sum_y_q <= sum_y_q + SUM_BITS'(y_q);
        sq_y_q  <= sq_y_q + SQ_BITS'(prod);
      end
      if (ctl.cmp_x) begin
        ok_x_q <= ok_x;
      end
      if (ctl.cmp_y) begin
        res_stable_q <= (cnt_q == CNT_FULL) && ok_x_q && ok_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_stable_q <= 1'b0;
      out_clr_q    <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q  <= 1'b1;
      out_stable_q <= res_stable_q;
      out_clr_q    <= res_clr_q;
    end else if (result_o.ready) begin
      out_valid_q  <= 1'b0;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.stable         = out_stable_q;
  assign result_o.window_cleared = out_clr_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("sample count beyond saturation");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_LAST)
    else $error("ring pointer out of range");

  a_empty_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> (sum_x_q == '0 && sq_x_q == '0))
    else $error("nonzero x sums with empty window");

  a_excl_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_stable_q && out_clr_q))
    else $error("stable and cleared in one result");

endmodule

// ----- rtl/wpsd_mul.sv -----
module wpsd_mul
  import wpsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic [SUM_BITS-1:0]  a_i,
  input  logic [SUM_BITS-1:0]  b_i,
  output logic [PROD_BITS-1:0] prod_o
);

  logic [PROD_BITS-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_BITS'(a_i) * PROD_BITS'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/wpsd_ring.sv -----
module wpsd_ring
  import wpsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [PTR_BITS-1:0]  waddr_i,
  input  logic [RING_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [PTR_BITS-1:0]  raddr_i,
  output logic [RING_BITS-1:0] rdata_o
);

  logic [RING_BITS-1:0] mem [WINDOW];
  logic [RING_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/wpsd_ctrl.sv -----
module wpsd_ctrl
  import wpsd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  logic  blob_i,
  input  logic  out_free_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          state_d = blob_i ? S_MUL_OX : S_DONE;
        end
      end
      S_MUL_OX: state_d = S_MUL_OY;
      S_MUL_OY: state_d = S_MUL_NX;
      S_MUL_NX: state_d = S_MUL_NY;
      S_MUL_NY: state_d = S_MUL_SX;
      S_MUL_SX: state_d = S_MUL_SY;
      S_MUL_SY: state_d = S_CMP_Y;
      S_CMP_Y:  state_d = S_DONE;
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.mul_sel = MUL_OLD_X;
    unique case (state_q)
      S_IDLE:   ctrl_o.ready = 1'b1;
      S_MUL_OX: ctrl_o.mul_sel = MUL_OLD_X;
      S_MUL_OY: begin
        ctrl_o.mul_sel = MUL_OLD_Y;
        ctrl_o.sub_x   = 1'b1;
      end
      S_MUL_NX: begin
        ctrl_o.mul_sel = MUL_NEW_X;
        ctrl_o.sub_y   = 1'b1;
      end
      S_MUL_NY: begin
        ctrl_o.mul_sel = MUL_NEW_Y;
        ctrl_o.add_x   = 1'b1;
      end
      S_MUL_SX: begin
        ctrl_o.mul_sel = MUL_SUM_X;
        ctrl_o.add_y   = 1'b1;
      end
      S_MUL_SY: begin
        ctrl_o.mul_sel = MUL_SUM_Y;
        ctrl_o.cmp_x   = 1'b1;
      end
      S_CMP_Y:  ctrl_o.cmp_y = 1'b1;
      S_DONE:   ctrl_o.out_load = out_free_i;
      default:  ctrl_o.ready = 1'b0;
    endcase
  end

endmodule
